@@ rtl/core/bal_pkg.sv @@
// ----------------------------------------------------------------------------
// bal_pkg
// Shared codes and the command/status bundles between the list controller
// and its datapath.
// ----------------------------------------------------------------------------
package bal_pkg;

    // Fixed field widths of the stream payloads and the configuration port.
    localparam int CMD_W   = 3;
    localparam int POS_W   = 4;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;
    localparam int LIMIT_W = 5;

    // Command codes carried in s_tuser.
    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd5;

    // Status codes returned with every result.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

    // Write port selects of the entry store.
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_POS  = 2'd1;  // item data at the item position
    localparam logic [1:0] WR_CNT  = 2'd2;  // item data at the end of the list
    localparam logic [1:0] WR_IDX  = 2'd3;  // read data at the shift index

    // Read port address selects of the entry store.
    localparam logic [2:0] RD_POS    = 3'd0;
    localparam logic [2:0] RD_LAST   = 3'd1;
    localparam logic [2:0] RD_IDX_DN = 3'd2;
    localparam logic [2:0] RD_IDX_UP = 3'd3;
    localparam logic [2:0] RD_ZERO   = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_item;
        logic       latch_status;
        logic       idx_load;
        logic       idx_dec;
        logic       idx_inc;
        logic [1:0] wr_sel;
        logic       rd_en;
        logic [2:0] rd_sel;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       cap_dout;
        logic       cap_first;
        logic       cap_last;
        logic       clr_ends;
        logic       out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             err;
        logic             shift_done;
        logic             count_zero;
        logic             out_free;
    } dp_stat_t;

endpackage

@@ rtl/core/bal_ram.sv @@
// ----------------------------------------------------------------------------
// bal_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/bal_ctrl.sv @@
// ----------------------------------------------------------------------------
// bal_ctrl
// Sequencer of the list: walks each command through execute, entry shifting,
// end-entry fetch and result hand-off.
// ----------------------------------------------------------------------------
module bal_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  bal_pkg::dp_stat_t stat,
    output bal_pkg::dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_RDWAIT = 4'd2;
    localparam logic [3:0] S_SH_RD  = 4'd3;
    localparam logic [3:0] S_SH_WR  = 4'd4;
    localparam logic [3:0] S_FIRST  = 4'd5;
    localparam logic [3:0] S_LAST   = 4'd6;
    localparam logic [3:0] S_LASTW  = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       is_insert;

    assign is_insert = (stat.cmd == bal_pkg::CMD_INSERT);
    assign s_tready  = (state_reg == S_IDLE);

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.latch_status = 1'b1;
                state_next       = S_FIRST;
                if (!stat.err) begin
                    case (stat.cmd)
                        bal_pkg::CMD_APPEND: begin
                            cmd.wr_sel  = bal_pkg::WR_CNT;
                            cmd.cnt_inc = 1'b1;
                        end
                        bal_pkg::CMD_POP: begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = bal_pkg::RD_LAST;
                            cmd.cnt_dec = 1'b1;
                            state_next  = S_RDWAIT;
                        end
                        bal_pkg::CMD_READ: begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = bal_pkg::RD_POS;
                            state_next = S_RDWAIT;
                        end
                        bal_pkg::CMD_REPLACE: begin
                            cmd.wr_sel = bal_pkg::WR_POS;
                        end
                        bal_pkg::CMD_INSERT, bal_pkg::CMD_DELETE: begin
                            cmd.idx_load = 1'b1;
                            state_next   = S_SH_RD;
                        end
                        default: begin
                            state_next = S_FIRST;
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                cmd.cap_dout = 1'b1;
                state_next   = S_FIRST;
            end
            // One entry moves per read/write pair until the gap is at its place.
            S_SH_RD: begin
                if (stat.shift_done) begin
                    if (is_insert) begin
                        cmd.wr_sel  = bal_pkg::WR_POS;
                        cmd.cnt_inc = 1'b1;
                    end else begin
                        cmd.cnt_dec = 1'b1;
                    end
                    state_next = S_FIRST;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = is_insert ? bal_pkg::RD_IDX_DN : bal_pkg::RD_IDX_UP;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cmd.wr_sel  = bal_pkg::WR_IDX;
                cmd.idx_dec = is_insert;
                cmd.idx_inc = !is_insert;
                state_next  = S_SH_RD;
            end
            // Fetch the first and last entries for the result.
            S_FIRST: begin
                if (stat.count_zero) begin
                    cmd.clr_ends = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = bal_pkg::RD_ZERO;
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                cmd.cap_first = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = bal_pkg::RD_LAST;
                state_next    = S_LASTW;
            end
            S_LASTW: begin
                cmd.cap_last = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/bal_dp.sv @@
// ----------------------------------------------------------------------------
// bal_dp
// Datapath of the list: item registers, entry count, capacity limit, entry
// store, shift index and the result output register.
// ----------------------------------------------------------------------------
module bal_dp #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    parameter int S_TDATA_W  = 40,
    parameter int M_TDATA_W  = 104
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [S_TDATA_W-1:0]           s_tdata,
    input  logic [bal_pkg::CMD_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [M_TDATA_W-1:0]           m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [bal_pkg::LIMIT_W-1:0]    cfg_wr_data,
    input  bal_pkg::dp_cmd_t               cmd,
    output bal_pkg::dp_stat_t              stat
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int XW  = (CW > bal_pkg::POS_W) ? CW : bal_pkg::POS_W;
    localparam int LW  = (CW > bal_pkg::LIMIT_W) ? CW : bal_pkg::LIMIT_W;
    localparam int DW  = DATA_WIDTH;
    localparam int RW  = 3 * DW + bal_pkg::STAT_W + bal_pkg::COUNT_W;

    logic [bal_pkg::CMD_W-1:0]  item_cmd_reg;
    logic [bal_pkg::POS_W-1:0]  item_pos_reg;
    logic [DW-1:0]              item_data_reg;
    logic [CW-1:0]              cnt_reg;
    logic [CW-1:0]              idx_reg;
    logic [LW-1:0]              limit_reg;
    logic [bal_pkg::STAT_W-1:0] st_reg;
    logic [DW-1:0]              dout_reg;
    logic [DW-1:0]              first_reg;
    logic [DW-1:0]              last_reg;
    logic                       m_valid_reg;
    logic [M_TDATA_W-1:0]       m_data_reg;

    logic [bal_pkg::STAT_W-1:0] st_next;
    logic [XW-1:0]              pos_x;
    logic [XW-1:0]              cnt_x;
    logic                       full;
    logic                       we;
    logic [AW-1:0]              waddr;
    logic [DW-1:0]              wdata;
    logic [AW-1:0]              raddr;
    logic [DW-1:0]              rdata;
    logic [RW-1:0]              result;

    // Command checks against the count before the command.
    assign pos_x = XW'(item_pos_reg);
    assign cnt_x = XW'(cnt_reg);
    assign full  = (LW'(cnt_reg) >= limit_reg) || (32'(cnt_reg) >= CAPACITY);

    always_comb begin
        st_next = bal_pkg::STAT_OK;
        case (item_cmd_reg)
            bal_pkg::CMD_APPEND: begin
                if (full) st_next = bal_pkg::STAT_FULL;
            end
            bal_pkg::CMD_POP: begin
                if (cnt_reg == '0) st_next = bal_pkg::STAT_EMPTY;
            end
            bal_pkg::CMD_READ, bal_pkg::CMD_REPLACE, bal_pkg::CMD_DELETE: begin
                if (pos_x >= cnt_x) st_next = bal_pkg::STAT_RANGE;
            end
            bal_pkg::CMD_INSERT: begin
                if (full) begin
                    st_next = bal_pkg::STAT_FULL;
                end else if (pos_x > cnt_x) begin
                    st_next = bal_pkg::STAT_RANGE;
                end
            end
            default: begin
                st_next = bal_pkg::STAT_OK;
            end
        endcase
    end

    // Status back to the controller.
    always_comb begin
        stat.cmd        = item_cmd_reg;
        stat.err        = (st_next != bal_pkg::STAT_OK);
        stat.count_zero = (cnt_reg == '0);
        stat.out_free   = !m_valid_reg || m_tready;
        if (item_cmd_reg == bal_pkg::CMD_INSERT) begin
            stat.shift_done = (XW'(idx_reg) == pos_x);
        end else begin
            stat.shift_done = ((CW + 1)'(idx_reg) + (CW + 1)'(1)) >= (CW + 1)'(cnt_reg);
        end
    end

    // Write port selection of the entry store.
    always_comb begin
        we    = (cmd.wr_sel != bal_pkg::WR_NONE);
        waddr = AW'(item_pos_reg);
        wdata = item_data_reg;
        case (cmd.wr_sel)
            bal_pkg::WR_POS: begin
                waddr = AW'(item_pos_reg);
                wdata = item_data_reg;
            end
            bal_pkg::WR_CNT: begin
                waddr = AW'(cnt_reg);
                wdata = item_data_reg;
            end
            bal_pkg::WR_IDX: begin
                waddr = AW'(idx_reg);
                wdata = rdata;
            end
            default: begin
                waddr = AW'(item_pos_reg);
                wdata = item_data_reg;
            end
        endcase
    end

    // Read address selection of the entry store.
    always_comb begin
        case (cmd.rd_sel)
            bal_pkg::RD_POS:    raddr = AW'(item_pos_reg);
            bal_pkg::RD_LAST:   raddr = AW'(cnt_reg - CW'(1));
            bal_pkg::RD_IDX_DN: raddr = AW'(idx_reg - CW'(1));
            bal_pkg::RD_IDX_UP: raddr = AW'(idx_reg + CW'(1));
            bal_pkg::RD_ZERO:   raddr = '0;
            default:            raddr = '0;
        endcase
    end

    bal_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Control registers: count and capacity limit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            limit_reg <= LW'(CAPACITY);
        end else begin
            if (cmd.cnt_inc) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (cmd.cnt_dec) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (cfg_wr_en) begin
                limit_reg <= LW'(cfg_wr_data);
            end
        end
    end

    // Item, shift index and result field registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_cmd_reg  <= s_tuser;
            item_pos_reg  <= s_tdata[bal_pkg::POS_W-1:0];
            item_data_reg <= s_tdata[bal_pkg::POS_W +: DW];
            dout_reg      <= '0;
        end else if (cmd.cap_dout) begin
            dout_reg <= rdata;
        end
        if (cmd.idx_load) begin
            idx_reg <= (item_cmd_reg == bal_pkg::CMD_INSERT) ? cnt_reg : CW'(item_pos_reg);
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_reg - CW'(1);
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (cmd.latch_status) begin
            st_reg <= st_next;
        end
        if (cmd.clr_ends) begin
            first_reg <= '0;
            last_reg  <= '0;
        end else begin
            if (cmd.cap_first) first_reg <= rdata;
            if (cmd.cap_last)  last_reg  <= rdata;
        end
    end

    // Result packing, lowest field first.
    assign result = {last_reg, first_reg, bal_pkg::COUNT_W'(cnt_reg), st_reg, dout_reg};

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= M_TDATA_W'(result);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ rtl/core/bounded_array_list_core.sv @@
// ----------------------------------------------------------------------------
// bounded_array_list_core
// Fixed-capacity ordered list of words with append, pop, read, replace,
// insert and delete commands, one result per command.
// ----------------------------------------------------------------------------
// Usage:
//   A command enters on the s_ stream: s_tuser carries the command code and
//   s_tdata the position and the data word. Each command returns exactly one
//   result transfer on the m_ stream with the value read or popped, a status
//   code, the entry count after the command and the first and last entries.
//   cfg_wr_en/cfg_wr_data set the capacity limit; write it only while idle.
// Command sequence:
//   Append, replace, failed and unused commands go from execute straight to
//   the fetch of the end entries and then to the output; read and pop add a
//   read wait. Insert and delete add a read and a write per entry moved,
//   because the entry store has one read and one write port and each move
//   is a read followed by a write. A command after which the list is empty
//   skips the fetch of the end entries. The next command is taken once the
//   result is loaded into the output register.
// Reset and stalls:
//   Reset empties the list and sets the limit to CAPACITY. A stalled receiver
//   holds the result in the output register; the block accepts the next
//   command meanwhile and waits with its result until the register frees.
// ----------------------------------------------------------------------------
module bounded_array_list_core #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: position, data_in (zero padding to bytes)
    input  logic [((bal_pkg::POS_W + DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // s_tuser: cmd
    input  logic [bal_pkg::CMD_W-1:0]           s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // m_tdata: data_out, status, entry_count, first_value, last_value
    output logic [((3 * DATA_WIDTH + bal_pkg::STAT_W + bal_pkg::COUNT_W + 7) / 8) * 8 - 1:0]
                                                m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [bal_pkg::LIMIT_W-1:0]         cfg_wr_data
);

    localparam int S_TDATA_W = ((bal_pkg::POS_W + DATA_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W =
        ((3 * DATA_WIDTH + bal_pkg::STAT_W + bal_pkg::COUNT_W + 7) / 8) * 8;

    bal_pkg::dp_cmd_t  dp_cmd;
    bal_pkg::dp_stat_t dp_stat;

    bal_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    bal_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .S_TDATA_W  (S_TDATA_W),
        .M_TDATA_W  (M_TDATA_W)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (dp_cmd),
        .stat        (dp_stat)
    );

endmodule

@@ rtl/core/bal_checker.sv @@
// ----------------------------------------------------------------------------
// bal_checker
// Port-level checks of the list core: input handshake, result stream
// behavior and the consistency of the result fields.
// ----------------------------------------------------------------------------
module bal_checker #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    parameter int M_TDATA_W  = 104
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    localparam int DW = DATA_WIDTH;

    logic [bal_pkg::STAT_W-1:0]  res_status;
    logic [bal_pkg::COUNT_W-1:0] res_count;
    logic [DW-1:0]               res_first;
    logic [DW-1:0]               res_last;

    assign res_status = m_tdata[DW +: bal_pkg::STAT_W];
    assign res_count  = m_tdata[DW + bal_pkg::STAT_W +: bal_pkg::COUNT_W];
    assign res_first  = m_tdata[DW + bal_pkg::STAT_W + bal_pkg::COUNT_W +: DW];
    assign res_last   = m_tdata[2 * DW + bal_pkg::STAT_W + bal_pkg::COUNT_W +: DW];

    // No result is offered right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result transfer holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // An empty report always comes with an empty list.
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_status == bal_pkg::STAT_EMPTY) |-> (res_count == '0))
        else $error("empty status with entries held");

    // An empty list shows zero first and last entries.
    a_empty_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_count == '0) |-> (res_first == '0) && (res_last == '0))
        else $error("end entries of an empty list not zero");

    // A command is never taken in the cycle right after another one.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a command is in progress");

endmodule

bind bounded_array_list_core bal_checker #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .M_TDATA_W  (M_TDATA_W)
) u_bal_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
